@@ src/emr_pkg.sv @@
`timescale 1ns / 1ps
package emr_pkg;

	localparam int MAX_COLS = 32;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CNT_W = COL_W + 1;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic valid;
		logic vert;
		col_t col;
		logic force_join;
		logic join_bit;
		logic down_bit;
	} link_req_t;

	typedef struct packed {
		col_t next_addr;
		col_t prev_addr;
	} list_rd_t;

	typedef struct packed {
		col_t next_data;
		col_t prev_data;
	} list_rdata_t;

	typedef struct packed {
		logic en;
		col_t next_addr0;
		col_t next_data0;
		col_t prev_addr0;
		col_t prev_data0;
		col_t next_addr1;
		col_t next_data1;
		col_t prev_addr1;
		col_t prev_data1;
	} list_wr_t;

endpackage

@@ src/emr_link_unit.sv @@
`timescale 1ns / 1ps
module emr_link_unit (
	input  emr_pkg::link_req_t   req,
	input  emr_pkg::list_rdata_t rdata,
	output emr_pkg::list_rd_t    rd,
	output emr_pkg::list_wr_t    wr,
	output logic                 set_bit
);

	emr_pkg::col_t tgt;
	logic          linked;
	logic          act;

	// horizontal: splice list of col+1 after col; vertical: unlink col
	always_comb begin
		tgt = req.vert ? req.col : req.col + emr_pkg::col_t'(1);
		rd.next_addr = req.col;
		rd.prev_addr = tgt;
		linked = rdata.next_data == tgt;
		if (req.vert) begin
			set_bit = linked || req.down_bit;
			act = !set_bit;
		end else begin
			act = !linked && (req.force_join || req.join_bit);
			set_bit = act;
		end
		wr.en = req.valid && act;
		wr.next_addr0 = rdata.prev_data;
		wr.next_data0 = rdata.next_data;
		wr.prev_addr0 = rdata.next_data;
		wr.prev_data0 = rdata.prev_data;
		wr.next_addr1 = req.col;
		wr.next_data1 = tgt;
		wr.prev_addr1 = tgt;
		wr.prev_data1 = req.col;
	end

endmodule

@@ src/emr_set_lists.sv @@
`timescale 1ns / 1ps
module emr_set_lists (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  emr_pkg::list_rd_t    rd,
	input  emr_pkg::list_wr_t    wr,
	output emr_pkg::list_rdata_t rdata
);

	emr_pkg::col_t next_q [emr_pkg::MAX_COLS];
	emr_pkg::col_t prev_q [emr_pkg::MAX_COLS];

	assign rdata.next_data = next_q[rd.next_addr];
	assign rdata.prev_data = prev_q[rd.prev_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < emr_pkg::MAX_COLS; i++) begin
				next_q[i] <= emr_pkg::col_t'(i);
				prev_q[i] <= emr_pkg::col_t'(i);
			end
		end else if (clear) begin
			for (int i = 0; i < emr_pkg::MAX_COLS; i++) begin
				next_q[i] <= emr_pkg::col_t'(i);
				prev_q[i] <= emr_pkg::col_t'(i);
			end
		end else if (wr.en) begin
			// second port wins on a shared address
			next_q[wr.next_addr0] <= wr.next_data0;
			next_q[wr.next_addr1] <= wr.next_data1;
			prev_q[wr.prev_addr0] <= wr.prev_data0;
			prev_q[wr.prev_addr1] <= wr.prev_data1;
		end
	end

endmodule

@@ src/eller_maze_row_generator.sv @@
`timescale 1ns / 1ps
// Eller maze row generator.
// Slave stream: one transfer per maze row. s_tdata[31:0] holds the join
// requests (bit c joins columns c and c+1), s_tdata[63:32] the down
// requests, s_tlast marks the final row of a maze.
// Master stream: one transfer per row. m_tdata[31:0] is right_open,
// m_tdata[63:32] is down_open.
// APB register at address 0 is num_cols (2..32); writing it also starts a
// new maze with every column in a set of its own.
// Each row walks the columns through one shared link unit, one column per
// cycle: a horizontal pass, then a vertical pass (skipped on the final row),
// then a step that loads the output register.
// The slave side is not ready while a row is being worked on.
// The output register lets the next row be taken while a result waits; a
// stalled receiver holds the block before loading its next result.
// Reset puts every column in its own set, num_cols to 32, outputs empty.
module eller_maze_row_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // join_bits, down_bits
	input  logic        s_tlast,   // last_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // right_open, down_open
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_HORIZ = 2'd1;
	localparam logic [1:0] ST_VERT  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                  state_q;
	emr_pkg::cnt_t               col_q;
	emr_pkg::cnt_t               n_q;
	emr_pkg::cnt_t               num_cols_q;
	emr_pkg::cnt_t               n_clamp;
	logic [emr_pkg::MAX_COLS-1:0] join_q;
	logic [emr_pkg::MAX_COLS-1:0] down_q;
	logic                        last_q;
	logic [emr_pkg::MAX_COLS-1:0] right_acc_q;
	logic [emr_pkg::MAX_COLS-1:0] down_acc_q;
	logic [63:0]                 m_tdata_q;
	logic                        m_tvalid_q;

	logic                 cfg_wr;
	logic                 in_xfer;
	logic                 horiz_step;
	logic                 vert_step;
	logic                 out_load;
	logic                 clear;
	emr_pkg::link_req_t   req;
	emr_pkg::list_rd_t    rd;
	emr_pkg::list_rdata_t rdata;
	emr_pkg::list_wr_t    wr;
	logic                 set_bit;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {26'd0, num_cols_q};
	assign cfg_wr = psel && penable && pwrite && !paddr[2];

	assign n_clamp = (num_cols_q > emr_pkg::cnt_t'(emr_pkg::MAX_COLS)) ?
		emr_pkg::cnt_t'(emr_pkg::MAX_COLS) : num_cols_q;

	assign s_tready = state_q == ST_IDLE;
	assign in_xfer = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	assign horiz_step = (state_q == ST_HORIZ) && ((col_q + emr_pkg::cnt_t'(1)) < n_q);
	assign vert_step = (state_q == ST_VERT) && (col_q < n_q);
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign clear = cfg_wr || ((state_q == ST_HORIZ) && !horiz_step && last_q);

	always_comb begin
		req.valid = horiz_step || vert_step;
		req.vert = state_q == ST_VERT;
		req.col = col_q[emr_pkg::COL_W-1:0];
		req.force_join = last_q;
		req.join_bit = join_q[col_q[emr_pkg::COL_W-1:0]];
		req.down_bit = down_q[col_q[emr_pkg::COL_W-1:0]];
	end

	emr_link_unit u_link (
		.req     (req),
		.rdata   (rdata),
		.rd      (rd),
		.wr      (wr),
		.set_bit (set_bit)
	);

	emr_set_lists u_lists (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= emr_pkg::cnt_t'(emr_pkg::MAX_COLS);
		end else if (cfg_wr) begin
			num_cols_q <= pwdata[emr_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_HORIZ;
						col_q <= '0;
					end
				end
				ST_HORIZ: begin
					if (horiz_step) begin
						col_q <= col_q + emr_pkg::cnt_t'(1);
					end else if (last_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_VERT;
						col_q <= '0;
					end
				end
				ST_VERT: begin
					if (vert_step) begin
						col_q <= col_q + emr_pkg::cnt_t'(1);
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			join_q <= s_tdata[31:0];
			down_q <= s_tdata[63:32];
			last_q <= s_tlast;
			n_q <= n_clamp;
			right_acc_q <= '0;
			down_acc_q <= '0;
		end else begin
			if (horiz_step && set_bit) begin
				right_acc_q[col_q[emr_pkg::COL_W-1:0]] <= 1'b1;
			end
			if (vert_step && set_bit) begin
				down_acc_q[col_q[emr_pkg::COL_W-1:0]] <= 1'b1;
			end
		end
		if (out_load) begin
			m_tdata_q <= {down_acc_q, right_acc_q};
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_HORIZ)
		else $error("row transfer did not start the horizontal pass");

	a_join_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(horiz_step && wr.en) |-> (rdata.prev_data != req.col))
		else $error("join splices a column into its own list");

	a_unlink_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(vert_step && wr.en) |-> (rdata.next_data != req.col && rdata.prev_data != req.col))
		else $error("unlinked column has a self pointer on one side only");

	a_last_no_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q) |-> (down_acc_q == '0))
		else $error("final row opened a column downward");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result load did not raise valid");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

	localparam logic [2:0] ADDR_NUM_COLS = 3'd0;
	localparam logic [2:0] ADDR_SPARE    = 3'd4;
	localparam int RANDOM_ROWS = 1530;
	localparam int QUIET_ROWS  = 200;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [31:0] down_open;
		logic [31:0] right_open;
	} row_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // join_bits, down_bits
	logic        s_tlast;   // last_row
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // right_open, down_open
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	eller_maze_row_generator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the column sets and the column count
	emr_pkg::col_t set_next [emr_pkg::MAX_COLS];
	emr_pkg::col_t set_prev [emr_pkg::MAX_COLS];
	logic [5:0]    cols_in_use;

	row_result_t pending_rows [$];
	int          mismatch_count;
	int          rows_sent;
	bit          src_idle_en;
	bit          rx_idle_en;
	bit          long_hold_req;
	int          rx_stall;

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic void reset_sets();
		for (int c = 0; c < emr_pkg::MAX_COLS; c++) begin
			set_next[c] = emr_pkg::col_t'(c);
			set_prev[c] = emr_pkg::col_t'(c);
		end
	endfunction

	function automatic row_result_t predict_row(logic [31:0] jb, logic [31:0] db, logic lr);
		row_result_t r;
		int n;
		emr_pkg::col_t an;
		emr_pkg::col_t bp;
		r = '0;
		n = (cols_in_use > emr_pkg::MAX_COLS) ? emr_pkg::MAX_COLS : int'(cols_in_use);
		// horizontal pass
		for (int c = 0; c + 1 < n; c++) begin
			if (int'(set_next[c]) != c + 1 && (lr || jb[c])) begin
				an = set_next[c];
				bp = set_prev[c+1];
				set_next[bp] = an;
				set_prev[an] = bp;
				set_next[c] = emr_pkg::col_t'(c + 1);
				set_prev[c+1] = emr_pkg::col_t'(c);
				r.right_open[c] = 1'b1;
			end
		end
		if (lr) begin
			reset_sets();
		end else begin
			// vertical pass
			for (int c = 0; c < n; c++) begin
				if (int'(set_next[c]) == c || db[c]) begin
					r.down_open[c] = 1'b1;
				end else begin
					an = set_next[c];
					bp = set_prev[c];
					set_next[bp] = an;
					set_prev[an] = bp;
					set_next[c] = emr_pkg::col_t'(c);
					set_prev[c] = emr_pkg::col_t'(c);
				end
			end
		end
		return r;
	endfunction

	// dense, sparse, plain or constant request masks
	function automatic logic [31:0] rand_mask();
		logic [31:0] a;
		logic [31:0] b;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 5))
			0: return a & b;
			1: return a | b;
			2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			default: return a;
		endcase
	endfunction

	task automatic send_row(input logic [31:0] jb, input logic [31:0] db, input logic lr);
		s_tvalid <= 1'b1;
		s_tdata  <= {db, jb};
		s_tlast  <= lr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_rows.insert(pending_rows.size(), predict_row(jb, db, lr));
		rows_sent++;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		wait_drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_NUM_COLS) begin
			cols_in_use = data[5:0];
			reset_sets();
		end
		@(posedge clk);
	endtask

	// receiver: random stalls, or a long hold on request
	initial begin
		m_tready = 1'b0;
		rx_stall = 0;
		forever begin
			@(posedge clk);
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_stall = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				rx_stall = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_rows.pop_front();
				if (m_tdata[31:0] !== want.right_open) begin
					$display("%0t: right_open expected %h actual %h",
						$time, want.right_open, m_tdata[31:0]);
					mismatch_count++;
				end
				if (m_tdata[63:32] !== want.down_open) begin
					$display("%0t: down_open expected %h actual %h",
						$time, want.down_open, m_tdata[63:32]);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_directed_rows();
		send_row(32'h0, 32'h0, 1'b0);
		send_row(32'hFFFF_FFFF, 32'h0, 1'b0);
		send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// pairs already linked: no new right passages
		send_row(32'hFFFF_FFFF, 32'h0, 1'b0);
		send_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_row(32'h0, 32'hFFFF_FFFF, 1'b1);
		send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_row(32'h8000_0001, 32'h7FFF_FFFE, 1'b0);
		send_row($urandom, $urandom, 1'b0);
		// write to an unused address leaves the sets alone
		write_reg(ADDR_SPARE, 32'h5);
		send_row($urandom, $urandom, 1'b0);
		send_row(32'h0, 32'h0, 1'b1);
	endtask

	task automatic test_column_counts();
		logic [5:0] counts [6];
		counts = '{6'd2, 6'd1, 6'd0, 6'd63, 6'd33, 6'd32};
		foreach (counts[i]) begin
			write_reg(ADDR_NUM_COLS, {$urandom_range(0, 1) ? 26'h3FF_FFFF : 26'h0, counts[i]});
			send_row($urandom, $urandom, 1'b0);
			send_row(32'hFFFF_FFFF, 32'h0, 1'b0);
		end
	endtask

	task automatic test_output_stall();
		wait_drain();
		long_hold_req = 1'b1;
		src_idle_en = 1'b0;
		repeat (8) send_row($urandom, $urandom, 1'b0);
		send_row($urandom, $urandom, 1'b1);
		wait_drain();
	endtask

	task automatic test_random_mazes();
		int target;
		int depth;
		logic [5:0] cols;
		target = rows_sent + RANDOM_ROWS;
		rx_idle_en = 1'b1;
		while (rows_sent < target) begin
			src_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en  = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0: cols = 6'($urandom_range(0, 1));
					1: cols = 6'($urandom_range(33, 63));
					2: cols = 6'd32;
					default: cols = 6'($urandom_range(2, 32));
				endcase
				write_reg(ADDR_NUM_COLS, {26'($urandom), cols});
			end
			depth = $urandom_range(1, 40);
			for (int r = 0; r < depth; r++) begin
				// mostly well-formed mazes, now and then a stray final row
				send_row(rand_mask(), rand_mask(), $urandom_range(0, 24) == 0);
			end
			send_row(rand_mask(), rand_mask(), 1'b1);
			if ($urandom_range(0, 4) == 0) wait_drain();
		end
	endtask

	task automatic test_quiet_finish();
		src_idle_en = 1'b0;
		rx_idle_en  = 1'b0;
		write_reg(ADDR_NUM_COLS, $urandom_range(2, 32));
		repeat (QUIET_ROWS) send_row(rand_mask(), rand_mask(), $urandom_range(0, 19) == 0);
	endtask

	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		rows_sent = 0;
		src_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		long_hold_req = 1'b0;
		cols_in_use = 6'd32;
		reset_sets();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_rows();
		test_column_counts();
		test_output_stall();
		test_random_mazes();
		test_quiet_finish();

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_rows.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * emr_pkg::MAX_COLS + 8) @(posedge clk);
		if (pending_rows.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %h actual none",
				$time, pending_rows.size(), pending_rows[0]);
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
